>>> src/mbe_pkg.sv
// mbe_pkg: widths, disc constants and shared types of the escape-time unit
// depends on nothing; used by every other file of the block
package mbe_pkg;

  localparam int FRAC_BITS = 28;
  localparam int IN_W      = 32;
  localparam int CNT_W     = 10;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(300);

  // in-range z: magnitude at most 2^(FRAC_BITS+1)
  localparam int ZW    = FRAC_BITS + 3;
  localparam int MAG_W = FRAC_BITS + 2;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int PR_W  = 2 * ZW;
  // freshly computed z before the range check
  localparam int NW    = ((FRAC_BITS + 3 > IN_W) ? FRAC_BITS + 3 : IN_W) + 2;
  // disc distances
  localparam int DW    = ((FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W) + 2;
  localparam int R2_W  = 2 * FRAC_BITS;

  localparam int NUM_DISCS = 6;
  localparam int STEP_W    = $clog2(NUM_DISCS + 1);

  localparam int QUEUE_DEPTH = 2;

  // constants rounded to nearest at FRAC_BITS fractional bits
  localparam logic [127:0] ONE_W   = 128'd1 << FRAC_BITS;
  localparam logic [127:0] CARD_XW = (128'd2 * ONE_W + 128'd10) / 128'd20;
  localparam logic [127:0] CARD_RW = (128'd12 * ONE_W + 128'd10) / 128'd20;
  localparam logic [127:0] QUARTW  = (128'd50 * ONE_W + 128'd100) / 128'd200;
  localparam logic [127:0] BULB_RW = (128'd650 * ONE_W + 128'd1000) / 128'd2000;
  localparam logic [127:0] P3_XW   = (128'd2618 * ONE_W + 128'd1000) / 128'd2000;
  localparam logic [127:0] P3_RW   = (128'd118 * ONE_W + 128'd1000) / 128'd2000;
  localparam logic [127:0] P4_XW   = (128'd27622 * ONE_W + 128'd10000) / 128'd20000;
  localparam logic [127:0] P4_RW   = (128'd26 * ONE_W + 128'd1000) / 128'd2000;

  localparam logic [127:0] CARD_R2W = CARD_RW * CARD_RW;
  localparam logic [127:0] BULB_R2W = BULB_RW * BULB_RW;
  localparam logic [127:0] QUART2W  = QUARTW * QUARTW;
  localparam logic [127:0] P3_R2W   = P3_RW * P3_RW;
  localparam logic [127:0] P4_R2W   = P4_RW * P4_RW;

  typedef enum logic [1:0] {
    SIDE_ANY,
    SIDE_NONPOS,
    SIDE_NONNEG
  } mbe_side_e;

  typedef struct packed {
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic [DW-1:0]        r;
    logic [R2_W-1:0]      r2;
    mbe_side_e            side;
  } mbe_disc_t;

  typedef struct packed {
    logic signed [IN_W-1:0] c_real;
    logic signed [IN_W-1:0] c_imag;
    logic                   interior;
  } mbe_item_t;

  function automatic mbe_disc_t disc_at(input logic [STEP_W-1:0] idx);
    mbe_disc_t d;
    d = '0;
    unique case (idx)
      STEP_W'(0): begin
        d.cx   = -$signed(CARD_XW[DW-1:0]);
        d.r    = CARD_RW[DW-1:0];
        d.r2   = CARD_R2W[R2_W-1:0];
        d.side = SIDE_NONPOS;
      end
      STEP_W'(1): begin
        d.cy   = -$signed(QUARTW[DW-1:0]);
        d.r    = BULB_RW[DW-1:0];
        d.r2   = BULB_R2W[R2_W-1:0];
        d.side = SIDE_NONNEG;
      end
      STEP_W'(2): begin
        d.cy   = $signed(QUARTW[DW-1:0]);
        d.r    = BULB_RW[DW-1:0];
        d.r2   = BULB_R2W[R2_W-1:0];
        d.side = SIDE_NONNEG;
      end
      STEP_W'(3): begin
        d.cx   = -$signed(ONE_W[DW-1:0]);
        d.r    = QUARTW[DW-1:0];
        d.r2   = QUART2W[R2_W-1:0];
        d.side = SIDE_ANY;
      end
      STEP_W'(4): begin
        d.cx   = -$signed(P3_XW[DW-1:0]);
        d.r    = P3_RW[DW-1:0];
        d.r2   = P3_R2W[R2_W-1:0];
        d.side = SIDE_ANY;
      end
      STEP_W'(5): begin
        d.cx   = -$signed(P4_XW[DW-1:0]);
        d.r    = P4_RW[DW-1:0];
        d.r2   = P4_R2W[R2_W-1:0];
        d.side = SIDE_ANY;
      end
      default: begin
        // zero radius: never a hit
        d = '0;
      end
    endcase
    return d;
  endfunction

endpackage

>>> src/mbe_point_if.sv
// mbe_point_if: valid/ready channel carrying one point c
// depends on mbe_pkg for the field width
interface mbe_point_if;
  logic                            valid;
  logic                            ready;
  logic signed [mbe_pkg::IN_W-1:0] c_real;
  logic signed [mbe_pkg::IN_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

>>> src/mbe_count_if.sv
// mbe_count_if: valid/ready channel carrying one escape count
// depends on mbe_pkg for the field width
interface mbe_count_if;
  logic                       valid;
  logic                       ready;
  logic [mbe_pkg::CNT_W-1:0]  escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink (input valid, input escape_count, output ready);
endinterface

>>> src/mandelbrot_escape_time_unit.sv
// mandelbrot_escape_time_unit: top level of the escape-time unit
// depends on mbe_pkg, mbe_point_if, mbe_count_if, mbe_front, mbe_queue, mbe_back
//
// takes points c in signed fixed point (FRAC_BITS fractional bits, Q4.28) on point_i and
// returns one escape count per point on result_o, in order. the front tests six interior
// discs (cardioid approximation, upper and lower bulbs, period-2 bulb, two small real-axis
// bulbs) one disc a cycle, taking no new point until the last one is pushed; a hit
// returns max_iterations with no iteration. every point goes through a short queue to
// the back with its disc result; the back's loop has one registered squaring step and
// one add/compare step per iteration. the front works on the next point while the back
// iterates, and the back's output register holds a finished count until it is taken.
// max_iterations resets to 300 and is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while the unit is idle, as the unit does not enforce this; a limit
// of zero gives a count of zero for every point outside the discs.
module mandelbrot_escape_time_unit #(
  parameter int QUEUE_DEPTH = mbe_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mbe_pkg::CNT_W-1:0] cfg_wdata_i,
  mbe_point_if.sink                 point_i,
  mbe_count_if.source               result_o
);
  import mbe_pkg::*;

  // iteration limit register
  logic [CNT_W-1:0] max_iter_q;

  // front to queue
  logic      push_valid, push_ready;
  mbe_item_t push_item;

  // queue to back
  logic      pop_valid, pop_ready;
  mbe_item_t pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  // disc classifier
  mbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_i      (point_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decouples the classifier from the iteration loop
  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // iteration loop and output register
  mbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (max_iter_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .result_o    (result_o)
  );

endmodule

>>> src/mbe_front.sv
// mbe_front: accepts points and runs the six interior disc tests, one disc a cycle
// depends on mbe_pkg and mbe_point_if
module mbe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  mbe_point_if.sink          point_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output mbe_pkg::mbe_item_t push_item_o
);
  import mbe_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_DISCS);

  logic                   busy_q, busy_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   hit_q, hit_d;
  logic                   eval_q, eval_d;
  logic                   gate_q, gate_d;
  logic signed [IN_W-1:0] x_q, y_q;
  logic [R2_W-1:0]        sqx_q, sqx_d, sqy_q, sqy_d, r2_q;

  logic                   accept, issue, side_ok, eval_hit, hit_all;
  mbe_disc_t              disc;
  logic signed [DW-1:0]   dx, dy;
  logic [DW-1:0]          mx, my;
  logic [FRAC_BITS-1:0]   ax, ay;
  logic [R2_W:0]          sum_sq;

  assign point_i.ready = !busy_q;
  assign accept        = point_i.valid && !busy_q;
  assign issue         = busy_q && (step_q != LAST_STEP);

  // stage one: distance to the disc centre, gated square
  always_comb begin
    disc = disc_at(step_q);
    dx   = DW'(x_q) - disc.cx;
    dy   = DW'(y_q) - disc.cy;
    mx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    unique case (disc.side)
      SIDE_NONPOS: side_ok = x_q[IN_W-1] || (x_q == '0);
      SIDE_NONNEG: side_ok = !x_q[IN_W-1];
      SIDE_ANY:    side_ok = 1'b1;
      default:     side_ok = 1'b0;
    endcase
    // a distance at or past the radius is a miss, so only small values are squared
    gate_d = side_ok && (mx < disc.r) && (my < disc.r);
    ax     = mx[FRAC_BITS-1:0];
    ay     = my[FRAC_BITS-1:0];
    sqx_d  = R2_W'(ax) * R2_W'(ax);
    sqy_d  = R2_W'(ay) * R2_W'(ay);
  end

  // stage two: compare against the squared radius
  assign sum_sq   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign eval_hit = eval_q && gate_q && (sum_sq < {1'b0, r2_q});
  assign hit_all  = hit_q || eval_hit;

  assign push_valid_o         = busy_q && (step_q == LAST_STEP);
  assign push_item_o.c_real   = x_q;
  assign push_item_o.c_imag   = y_q;
  assign push_item_o.interior = hit_all;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    hit_d  = hit_all;
    eval_d = issue;
    if (issue) begin
      step_d = step_q + STEP_W'(1);
    end
    if (push_valid_o && push_ready_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
      hit_d  = 1'b0;
      eval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      hit_q  <= 1'b0;
      eval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      hit_q  <= hit_d;
      eval_q <= eval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= point_i.c_real;
      y_q <= point_i.c_imag;
    end
    if (issue) begin
      gate_q <= gate_d;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      r2_q   <= disc.r2;
    end
  end

endmodule

>>> src/mbe_queue.sv
// mbe_queue: short register queue between the disc tests and the iteration loop
// depends on mbe_pkg for the item type
module mbe_queue #(
  parameter int DEPTH = mbe_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  mbe_pkg::mbe_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output mbe_pkg::mbe_item_t pop_item_o
);
  import mbe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mbe_item_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> src/mbe_back.sv
// mbe_back: z = z^2 + c iteration loop (multiply and add steps) and output register
// depends on mbe_pkg and mbe_count_if
module mbe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mbe_pkg::CNT_W-1:0] limit_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  mbe_pkg::mbe_item_t        pop_item_i,
  mbe_count_if.source               result_o
);
  import mbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [SQ_W:0]          ESC_LIM = (SQ_W + 1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [NW-1:0]   N_LIM   = NW'(64'd1 << (FRAC_BITS + 1));
  localparam logic signed [ZW-1:0]   Z_LIM   = ZW'(64'd1 << (FRAC_BITS + 1));

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       k_q, k_d, res_q, res_d, count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [IN_W-1:0] x_q, y_q;
  logic signed [ZW-1:0]   zr_q, zr_d, zi_q, zi_d;
  logic [SQ_W-1:0]        sr_q, sr_d, si_q, si_d;
  logic signed [PR_W-1:0] p_q, p_d;

  logic                   res_free, do_pop, esc, in_range;
  logic signed [ZW-1:0]   zr_abs, zi_abs;
  logic [MAG_W-1:0]       mr, mi;
  logic [SQ_W:0]          sum;
  logic signed [SQ_W:0]   re;
  logic signed [SQ_W:0]   re_sh;
  logic signed [PR_W-1:0] im_sh;
  logic signed [NW-1:0]   nzr, nzi;

  assign res_free              = !out_valid_q || result_o.ready;
  assign pop_ready_o           = (state_q == ST_IDLE);
  assign do_pop                = pop_valid_i && pop_ready_o;
  assign result_o.valid        = out_valid_q;
  assign result_o.escape_count = count_q;

  // multiply step: squares of the magnitudes and the cross product
  always_comb begin
    zr_abs = zr_q[ZW-1] ? -zr_q : zr_q;
    zi_abs = zi_q[ZW-1] ? -zi_q : zi_q;
    mr     = zr_abs[MAG_W-1:0];
    mi     = zi_abs[MAG_W-1:0];
    sr_d   = SQ_W'(mr) * SQ_W'(mr);
    si_d   = SQ_W'(mi) * SQ_W'(mi);
    p_d    = zr_q * zi_q;
  end

  // add step: escape test and the next z
  always_comb begin
    sum      = {1'b0, sr_q} + {1'b0, si_q};
    esc      = (sum > ESC_LIM);
    re       = $signed({1'b0, sr_q}) - $signed({1'b0, si_q});
    re_sh    = re >>> FRAC_BITS;
    im_sh    = p_q >>> (FRAC_BITS - 1);
    nzr      = NW'(re_sh) + NW'(x_q);
    nzi      = NW'(im_sh) + NW'(y_q);
    // past the limit on either axis the new |z|^2 is above 4
    in_range = (nzr <= N_LIM) && (nzr >= -N_LIM) && (nzi <= N_LIM) && (nzi >= -N_LIM);
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    res_d       = res_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    out_valid_d = out_valid_q && !result_o.ready;
    count_d     = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_pop) begin
          zr_d = '0;
          zi_d = '0;
          k_d  = '0;
          if (pop_item_i.interior) begin
            res_d   = limit_i;
            state_d = ST_FIN;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        priority if (esc) begin
          res_d   = k_q - CNT_W'(1);
          state_d = ST_FIN;
        end else if (k_q == limit_i) begin
          res_d   = limit_i;
          state_d = ST_FIN;
        end else if (!in_range) begin
          res_d   = k_q;
          state_d = ST_FIN;
        end else begin
          zr_d    = ZW'(nzr);
          zi_d    = ZW'(nzi);
          k_d     = k_q + CNT_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        if (res_free) begin
          out_valid_d = 1'b1;
          count_d     = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      x_q <= pop_item_i.c_real;
      y_q <= pop_item_i.c_imag;
    end
    if (state_q == ST_MUL) begin
      sr_q <= sr_d;
      si_q <= si_d;
      p_q  <= p_d;
    end
    res_q   <= res_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    count_q <= count_d;
  end

`ifndef ASSERT_OFF
  a_count_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q <= limit_i))
    else $error("escape count above the iteration limit");

  a_k_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (k_q <= limit_i))
    else $error("iteration counter ran past the limit");

  a_z_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> ((zr_q <= Z_LIM) && (zr_q >= -Z_LIM) &&
                             (zi_q <= Z_LIM) && (zi_q >= -Z_LIM)))
    else $error("z entered the multiplier out of range");

  a_no_escape_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_ADD) && (k_q == '0)) |-> !esc)
    else $error("escape seen before the first iteration");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> ((state_q == ST_MUL) || (state_q == ST_FIN)))
    else $error("popped point did not start work");
`endif

endmodule
